/* rtl/rmes_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmes_pkg: shared types, constants and functions
// Region and result transaction types, the event record handed from the
// accumulating front end to the CORDIC back end, and the trig table builder.
// ----------------------------------------------------------------------------
package rmes_pkg;

  localparam int NPHI_DEFAULT         = 18;
  localparam int MAX_REGIONS_DEFAULT  = 512;
  localparam int CORDIC_STEPS_DEFAULT = 16;

  localparam int ENERGY_W   = 10;
  localparam int PHI_W      = 5;
  localparam int ETA_W      = 5;
  localparam int TALLY_W    = 9;
  localparam int MAG_W      = 23;
  localparam int ANGLE_W    = 16;
  localparam int TRIG_W     = 16;
  localparam int PHI_SLOTS  = 1 << PHI_W;
  localparam int PROD_W     = ENERGY_W + TRIG_W + 1;
  localparam int SUM_W      = 36;
  localparam int TURN_W     = 32;
  localparam int CORDIC_W   = SUM_W + 4;
  localparam int MAG_HALF   = CORDIC_W / 2;
  localparam int GAIN_W     = 20;
  localparam int TOT_W      = CORDIC_W + GAIN_W + 1;
  localparam int MAG_SHIFT  = 31;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [GAIN_W-1:0] GAIN_Q20   = GAIN_W'(636752);
  localparam logic [TOT_W-1:0]  MAG_ROUND  = TOT_W'(64'd1 << (MAG_SHIFT - 1));
  localparam logic [TURN_W-1:0] TURN_HALF  = 32'h8000_0000;
  localparam logic [TURN_W-1:0] ANGLE_RND  = 32'h0000_8000;
  localparam longint ROT_START = 64'sd652032874;

  localparam int ATAN_STEPS = 30;
  localparam int ATAN_IDX_W = $clog2(ATAN_STEPS);
  localparam logic [TURN_W-1:0] ATAN_TURNS [ATAN_STEPS] = '{
    32'h20000000, 32'h12e4051d, 32'h09fb385b, 32'h051111d4, 32'h028b0d43,
    32'h0145d7e1, 32'h00a2f61e, 32'h00517c55, 32'h0028be53, 32'h00145f2e,
    32'h000a2f98, 32'h000517cc, 32'h00028be6, 32'h000145f3, 32'h0000a2f9,
    32'h0000517c, 32'h000028be, 32'h0000145f, 32'h00000a2f, 32'h00000517,
    32'h0000028b, 32'h00000145, 32'h000000a2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000a, 32'h00000005, 32'h00000002, 32'h00000001
  };

  typedef struct packed {
    logic [ENERGY_W-1:0] region_energy;
    logic [PHI_W-1:0]    phi_index;
    logic [ETA_W-1:0]    eta_index;
    logic                region_overflow;
    logic                last_region;
  } region_t;

  typedef struct packed {
    logic [MAG_W-1:0]          missing_magnitude;
    logic signed [ANGLE_W-1:0] missing_angle;
    logic [TALLY_W-1:0]        overflow_count;
    logic [ENERGY_W-1:0]       peak_energy;
    logic [PHI_W-1:0]          peak_phi;
    logic [ETA_W-1:0]          peak_eta;
  } result_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic [TALLY_W-1:0]      overflow_count;
    logic [ENERGY_W-1:0]     peak_energy;
    logic [PHI_W-1:0]        peak_phi;
    logic [ETA_W-1:0]        peak_eta;
  } event_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ROTATE,
    BK_MULT,
    BK_SCALE
  } back_state_t;

  function automatic longint round_q15(input longint v);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (r > 64'sd32767) r = 64'sd32767;
    if (r < -64'sd32767) r = -64'sd32767;
    return r;
  endfunction

  // Rotation CORDIC on a phase in 2^-32 turns; returns {cos, sin} in Q1.15.
  function automatic logic [2*TRIG_W-1:0] trig_pair(input logic [TURN_W-1:0] phase);
    longint t;
    longint x;
    longint y;
    longint dx;
    longint dy;
    longint c;
    longint s;
    logic   neg;
    t = longint'({32'd0, phase});
    if (phase >= TURN_HALF) t = t - 64'sh1_0000_0000;
    neg = 1'b0;
    x = ROT_START;
    y = 64'sd0;
    if (t > 64'sh4000_0000) begin
      t = t - 64'sh8000_0000;
      neg = 1'b1;
    end else if (t < -64'sh4000_0000) begin
      t = t + 64'sh8000_0000;
      neg = 1'b1;
    end
    for (int i = 0; i < ATAN_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (t >= 0) begin
        x = x - dx;
        y = y + dy;
        t = t - longint'({32'd0, ATAN_TURNS[i]});
      end else begin
        x = x + dx;
        y = y - dy;
        t = t + longint'({32'd0, ATAN_TURNS[i]});
      end
    end
    c = round_q15(x);
    s = round_q15(y);
    if (neg) begin
      c = -c;
      s = -s;
    end
    return {c[TRIG_W-1:0], s[TRIG_W-1:0]};
  endfunction

endpackage

/* rtl/rmes_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmes_front: region intake and event accumulation
// Weights each region by its trig table entry, keeps the saturating x/y sums,
// the overflow tally and the peak region, and pushes one record per event.
// ----------------------------------------------------------------------------
module rmes_front import rmes_pkg::*; #(
  parameter int NPHI        = NPHI_DEFAULT,
  parameter int MAX_REGIONS = MAX_REGIONS_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    region_valid,
  output logic    region_ready,
  input  region_t region,
  output logic    push_valid,
  input  logic    push_ready,
  output event_t  push_data
);

  localparam int CNT_W = $clog2(MAX_REGIONS + 1);
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // Tables cover every 5-bit index; indexes past NPHI wrap at elaboration.
  logic signed [TRIG_W-1:0] cos_tab [PHI_SLOTS];
  logic signed [TRIG_W-1:0] sin_tab [PHI_SLOTS];

  for (genvar j = 0; j < PHI_SLOTS; j++) begin : g_trig
    localparam logic [TURN_W-1:0] PHASE = TURN_W'((64'(j % NPHI) << 32) / NPHI);
    localparam logic [2*TRIG_W-1:0] PAIR = trig_pair(PHASE);
    assign cos_tab[j] = PAIR[2*TRIG_W-1:TRIG_W];
    assign sin_tab[j] = PAIR[TRIG_W-1:0];
  end

  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0]  acc,
    input logic signed [PROD_W-1:0] prod
  );
    logic [SUM_W:0] t;
    t = {acc[SUM_W-1], acc} + (SUM_W+1)'(prod);
    if (t[SUM_W] != t[SUM_W-1]) return t[SUM_W] ? SUM_MIN : SUM_MAX;
    return t[SUM_W-1:0];
  endfunction

  // Product stage
  logic                      a_valid;
  logic signed [PROD_W-1:0]  a_prod_x;
  logic signed [PROD_W-1:0]  a_prod_y;
  logic [ENERGY_W-1:0]       a_energy;
  logic [PHI_W-1:0]          a_phi;
  logic [ETA_W-1:0]          a_eta;
  logic                      a_ov;
  logic                      a_last;

  // Event accumulators
  logic signed [SUM_W-1:0]   sum_x;
  logic signed [SUM_W-1:0]   sum_y;
  logic [TALLY_W-1:0]        tally;
  logic                      best_valid;
  logic [ENERGY_W-1:0]       best_energy;
  logic [PHI_W-1:0]          best_phi;
  logic [ETA_W-1:0]          best_eta;
  logic [CNT_W-1:0]          count;

  logic signed [SUM_W-1:0]   sum_x_next;
  logic signed [SUM_W-1:0]   sum_y_next;
  logic [TALLY_W-1:0]        tally_next;
  logic                      best_valid_next;
  logic [ENERGY_W-1:0]       best_energy_next;
  logic [PHI_W-1:0]          best_phi_next;
  logic [ETA_W-1:0]          best_eta_next;
  logic [CNT_W-1:0]          count_next;
  logic                      take;
  logic                      fire;

  assign push_valid   = a_valid && a_last;
  assign region_ready = !(a_valid && a_last && !push_ready);
  assign fire         = a_valid && region_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (region_ready) begin
      a_valid <= region_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (region_valid && region_ready) begin
      a_prod_x <= $signed({1'b0, region.region_energy}) * cos_tab[region.phi_index];
      a_prod_y <= $signed({1'b0, region.region_energy}) * sin_tab[region.phi_index];
      a_energy <= region.region_energy;
      a_phi    <= region.phi_index;
      a_eta    <= region.eta_index;
      a_ov     <= region.region_overflow;
      a_last   <= region.last_region;
    end
  end

  always_comb begin
    take             = count < CNT_W'(MAX_REGIONS);
    sum_x_next       = sum_x;
    sum_y_next       = sum_y;
    tally_next       = tally;
    best_valid_next  = best_valid;
    best_energy_next = best_energy;
    best_phi_next    = best_phi;
    best_eta_next    = best_eta;
    count_next       = count;
    if (take) begin
      count_next = count + CNT_W'(1);
      sum_x_next = sat_add(sum_x, a_prod_x);
      sum_y_next = sat_add(sum_y, a_prod_y);
      if (a_ov && (tally != {TALLY_W{1'b1}})) tally_next = tally + TALLY_W'(1);
      // Strict compare keeps the first region on a tie.
      if (!best_valid || (a_energy > best_energy)) begin
        best_valid_next  = 1'b1;
        best_energy_next = a_energy;
        best_phi_next    = a_phi;
        best_eta_next    = a_eta;
      end
    end
    push_data.sum_x          = sum_x_next;
    push_data.sum_y          = sum_y_next;
    push_data.overflow_count = tally_next;
    push_data.peak_energy    = best_valid_next ? best_energy_next : '0;
    push_data.peak_phi       = best_valid_next ? best_phi_next : '0;
    push_data.peak_eta       = best_valid_next ? best_eta_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && a_last)) begin
      sum_x       <= '0;
      sum_y       <= '0;
      tally       <= '0;
      best_valid  <= 1'b0;
      best_energy <= '0;
      best_phi    <= '0;
      best_eta    <= '0;
      count       <= '0;
    end else if (fire) begin
      sum_x       <= sum_x_next;
      sum_y       <= sum_y_next;
      tally       <= tally_next;
      best_valid  <= best_valid_next;
      best_energy <= best_energy_next;
      best_phi    <= best_phi_next;
      best_eta    <= best_eta_next;
      count       <= count_next;
    end
  end

endmodule

/* rtl/rmes_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmes_queue: event record queue
// Small FIFO of finished event records between the accumulator and the
// CORDIC back end, so either side can stall on its own.
// ----------------------------------------------------------------------------
module rmes_queue import rmes_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  output logic   push_ready,
  input  event_t push_data,
  output logic   pop_valid,
  input  logic   pop_ready,
  output event_t pop_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  event_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = fill != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

/* rtl/rmes_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmes_back: vector magnitude and angle
// Vectoring CORDIC over one event record, gain correction split into two
// half-width products, and the result register toward the receiver.
// ----------------------------------------------------------------------------
module rmes_back import rmes_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    pop_valid,
  output logic    pop_ready,
  input  event_t  pop_data,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result,
  output logic    busy
);

  localparam int STEP_W = $clog2(CORDIC_STEPS);

  back_state_t               state;
  back_state_t               state_next;
  logic signed [CORDIC_W-1:0] x;
  logic signed [CORDIC_W-1:0] y;
  logic [TURN_W-1:0]         z;
  logic [STEP_W-1:0]         step;
  logic                      zero_vec;
  logic [TALLY_W-1:0]        ev_tally;
  logic [ENERGY_W-1:0]       ev_energy;
  logic [PHI_W-1:0]          ev_phi;
  logic [ETA_W-1:0]          ev_eta;
  logic [2*MAG_HALF-1:0]     p_lo;
  logic [2*MAG_HALF-1:0]     p_hi;

  logic signed [CORDIC_W-1:0] sx;
  logic signed [CORDIC_W-1:0] sy;
  logic signed [CORDIC_W-1:0] dx;
  logic signed [CORDIC_W-1:0] dy;
  logic [TURN_W-1:0]         atan;
  logic [TOT_W-1:0]          total;
  logic [TURN_W-1:0]         z_rnd;
  logic                      slot_free;
  result_t                   res_next;

  assign pop_ready = state == BK_IDLE;
  assign busy      = state != BK_IDLE;
  assign slot_free = !result_valid || result_ready;

  always_comb begin
    sx    = CORDIC_W'(pop_data.sum_x);
    sy    = CORDIC_W'(pop_data.sum_y);
    dx    = y >>> step;
    dy    = x >>> step;
    atan  = ATAN_TURNS[ATAN_IDX_W'(step)];
    total = (TOT_W'(p_hi) << MAG_HALF) + TOT_W'(p_lo) + MAG_ROUND;
    z_rnd = z + ANGLE_RND;

    res_next.overflow_count = ev_tally;
    res_next.peak_energy    = ev_energy;
    res_next.peak_phi       = ev_phi;
    res_next.peak_eta       = ev_eta;
    if (zero_vec) begin
      res_next.missing_magnitude = '0;
      res_next.missing_angle     = '0;
    end else begin
      if (|total[TOT_W-1:MAG_SHIFT+MAG_W]) begin
        res_next.missing_magnitude = {MAG_W{1'b1}};
      end else begin
        res_next.missing_magnitude = total[MAG_SHIFT+MAG_W-1:MAG_SHIFT];
      end
      res_next.missing_angle = z_rnd[TURN_W-1:TURN_W-ANGLE_W];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE:   if (pop_valid) state_next = BK_ROTATE;
      BK_ROTATE: if (step == STEP_W'(CORDIC_STEPS - 1)) state_next = BK_MULT;
      BK_MULT:   state_next = BK_SCALE;
      BK_SCALE:  if (slot_free) state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (pop_valid) begin
          // The vector is (-sum_x, -sum_y); fold it into the right half-plane.
          if (pop_data.sum_x > 0) begin
            x <= sx;
            y <= sy;
            z <= TURN_HALF;
          end else begin
            x <= -sx;
            y <= -sy;
            z <= '0;
          end
          step      <= '0;
          zero_vec  <= (pop_data.sum_x == '0) && (pop_data.sum_y == '0);
          ev_tally  <= pop_data.overflow_count;
          ev_energy <= pop_data.peak_energy;
          ev_phi    <= pop_data.peak_phi;
          ev_eta    <= pop_data.peak_eta;
        end
      end
      BK_ROTATE: begin
        if (!y[CORDIC_W-1]) begin
          x <= x + dx;
          y <= y - dy;
          z <= z + atan;
        end else begin
          x <= x - dx;
          y <= y + dy;
          z <= z - atan;
        end
        step <= step + STEP_W'(1);
      end
      BK_MULT: begin
        p_lo <= x[MAG_HALF-1:0] * GAIN_Q20;
        p_hi <= x[CORDIC_W-1:MAG_HALF] * GAIN_Q20;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == BK_SCALE && slot_free) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == BK_SCALE && slot_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

endmodule

/* rtl/region_missing_et_sum_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_missing_et_sum_unit: missing transverse energy from regions
// Accumulates calorimeter regions into a vector sum and reports its
// magnitude, angle, overflow count and peak region once per event.
// ----------------------------------------------------------------------------
// Usage:
//   Regions enter on region_valid/region_ready, one transaction per cycle
//   while region_ready is high. The transaction with last_region set closes
//   the event; it alone causes a result transaction on
//   result_valid/result_ready. Its record passes the product stage, the record
//   queue, the CORDIC (one step a cycle), the gain product and the scaling
//   state. Regions stream at one per cycle while region_ready is high; the
//   CORDIC finish of one event runs while the next event accumulates. An
//   event must span at least CORDIC_STEPS + 3 regions to keep the input
//   stream free of stalls, and a two-deep record queue absorbs short bursts
//   of small events. When the receiver stalls, the result is held in the
//   output register, the back end holds one more record, the queue fills, and
//   then region_ready drops on the next last region until space opens.
//   Reset (rst, synchronous) empties the queue, drops result_valid and
//   clears the event sums; the trig tables are constants and need no setup.
// ----------------------------------------------------------------------------
module region_missing_et_sum_unit import rmes_pkg::*; #(
  parameter int NPHI         = NPHI_DEFAULT,
  parameter int MAX_REGIONS  = MAX_REGIONS_DEFAULT,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    region_valid,
  output logic    region_ready,
  input  region_t region,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  logic   push_valid;
  logic   push_ready;
  event_t push_data;
  logic   pop_valid;
  logic   pop_ready;
  event_t pop_data;
  logic   back_busy;

  rmes_front #(
    .NPHI        (NPHI),
    .MAX_REGIONS (MAX_REGIONS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .region_valid (region_valid),
    .region_ready (region_ready),
    .region       (region),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_data    (push_data)
  );

  rmes_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  rmes_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_data     (pop_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .busy         (back_busy)
  );

  // The queue holds no record right after reset.
  a_queue_empty_after_reset: assert property (@(posedge clk) rst |=> !pop_valid)
    else $error("event queue not empty after reset");

  // A new result only appears after the back end has worked on a record.
  a_result_from_back: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(back_busy))
    else $error("result raised without back end activity");

  // Region intake only stalls when the record queue is full.
  a_stall_only_on_full: assert property (@(posedge clk) disable iff (rst)
    !region_ready |-> (push_valid && !push_ready))
    else $error("region intake stalled while queue has space");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: region_missing_et_sum_unit regression
// Streams calorimeter regions grouped into events through the unit and checks
// every result transaction against an in-bench model of the vector sum,
// vectoring CORDIC, overflow tally and peak region search. Covers corner
// events, the region limit of an event, random traffic under two idle
// patterns, and a long output stall that backs up the input.
// ----------------------------------------------------------------------------
module testbench import rmes_pkg::*; ();

  localparam int N_PHI          = NPHI_DEFAULT;
  localparam int REGION_LIMIT   = MAX_REGIONS_DEFAULT;
  localparam int ROT_STEPS      = CORDIC_STEPS_DEFAULT;
  localparam int RESULT_LATENCY = ROT_STEPS + 4;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int STALL_CYCLES   = 400;
  localparam longint ACC_MAX    = 64'sd34359738367;
  localparam longint ACC_MIN    = -64'sd34359738368;
  localparam longint MAG_MAX    = 64'sd8388607;
  localparam int TALLY_MAX      = 511;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    region_valid = 1'b0;
  logic    region_ready;
  region_t region_in = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result_out;

  region_missing_et_sum_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .region_valid (region_valid),
    .region_ready (region_ready),
    .region       (region_in),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_out)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Event accumulation state of the model.
  longint      cos_tab [N_PHI];
  longint      sin_tab [N_PHI];
  longint      acc_x;
  longint      acc_y;
  int          tally_acc;
  int          best_e;
  logic [4:0]  best_ph;
  logic [4:0]  best_et;
  int          seen_count;

  result_t     pending_results [$];
  int          error_count = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          stall_left = 0;
  int          idle_cycles = 0;
  logic [9:0]  tie_energy = 10'd0;

  function automatic longint q15_round(input longint v);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (r > 64'sd32767) r = 64'sd32767;
    if (r < -64'sd32767) r = -64'sd32767;
    return r;
  endfunction

  function automatic longint clamp_sum(input longint v);
    if (v > ACC_MAX) return ACC_MAX;
    if (v < ACC_MIN) return ACC_MIN;
    return v;
  endfunction

  // Q1.15 cos/sin per phi slot, from a 30-step rotation on the folded phase.
  function automatic void build_trig_tables();
    longint ph;
    longint t;
    longint x;
    longint y;
    longint dx;
    longint dy;
    bit     neg;
    for (int k = 0; k < N_PHI; k++) begin
      ph = (longint'(k) <<< 32) / N_PHI;
      t = (ph >= 64'sh8000_0000) ? ph - 64'sh1_0000_0000 : ph;
      neg = 1'b0;
      x = ROT_START;
      y = 64'sd0;
      if (t > 64'sh4000_0000) begin
        t = t - 64'sh8000_0000;
        neg = 1'b1;
      end else if (t < -64'sh4000_0000) begin
        t = t + 64'sh8000_0000;
        neg = 1'b1;
      end
      for (int i = 0; i < ATAN_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (t >= 0) begin
          x = x - dx;
          y = y + dy;
          t = t - longint'({32'd0, ATAN_TURNS[i]});
        end else begin
          x = x + dx;
          y = y - dy;
          t = t + longint'({32'd0, ATAN_TURNS[i]});
        end
      end
      cos_tab[k] = neg ? -q15_round(x) : q15_round(x);
      sin_tab[k] = neg ? -q15_round(y) : q15_round(y);
    end
  endfunction

  function automatic void clear_event_state();
    acc_x = 0;
    acc_y = 0;
    tally_acc = 0;
    best_e = -1;
    best_ph = '0;
    best_et = '0;
    seen_count = 0;
  endfunction

  // Adds one region to the event; returns 1 with the event summary on the
  // region that closes the event.
  function automatic bit fold_region(input region_t r, output result_t res);
    longint      vx;
    longint      vy;
    longint      dx;
    longint      dy;
    longint      mag;
    logic [31:0] z;
    logic [31:0] zr;
    int          idx;
    res = '0;
    if (seen_count < REGION_LIMIT) begin
      idx = int'(r.phi_index) % N_PHI;
      seen_count++;
      if (r.region_overflow && tally_acc < TALLY_MAX) tally_acc++;
      acc_x = clamp_sum(acc_x + longint'(r.region_energy) * cos_tab[idx]);
      acc_y = clamp_sum(acc_y + longint'(r.region_energy) * sin_tab[idx]);
      if (int'(r.region_energy) > best_e) begin
        best_e = int'(r.region_energy);
        best_ph = r.phi_index;
        best_et = r.eta_index;
      end
    end
    if (!r.last_region) return 1'b0;

    vx = -acc_x;
    vy = -acc_y;
    z = 32'd0;
    mag = 0;
    if (vx != 0 || vy != 0) begin
      // Fold into the right half-plane; a folded vector starts at half a turn.
      if (vx < 0) begin
        vx = -vx;
        vy = -vy;
        z = TURN_HALF;
      end
      for (int i = 0; i < ROT_STEPS && i < ATAN_STEPS; i++) begin
        dx = vy >>> i;
        dy = vx >>> i;
        if (vy >= 0) begin
          vx = vx + dx;
          vy = vy - dy;
          z = z + ATAN_TURNS[i];
        end else begin
          vx = vx - dx;
          vy = vy + dy;
          z = z - ATAN_TURNS[i];
        end
      end
      mag = (vx * longint'(GAIN_Q20) + (64'sd1 <<< 30)) >>> 31;
      if (mag > MAG_MAX) mag = MAG_MAX;
      zr = z + ANGLE_RND;
      z = {16'd0, zr[31:16]};
    end
    res.missing_magnitude = mag[MAG_W-1:0];
    res.missing_angle = z[ANGLE_W-1:0];
    res.overflow_count = tally_acc[TALLY_W-1:0];
    if (best_e >= 0) begin
      res.peak_energy = best_e[ENERGY_W-1:0];
      res.peak_phi = best_ph;
      res.peak_eta = best_et;
    end
    clear_event_state();
    return 1'b1;
  endfunction

  function automatic region_t make_region(input int e, input int ph, input int eta,
                                          input bit ov, input bit last);
    region_t r;
    r.region_energy = e[ENERGY_W-1:0];
    r.phi_index = ph[PHI_W-1:0];
    r.eta_index = eta[ETA_W-1:0];
    r.region_overflow = ov;
    r.last_region = last;
    return r;
  endfunction

  function automatic region_t random_region(input bit last);
    region_t r;
    case ($urandom_range(7))
      0: r.region_energy = 10'd0;
      1: r.region_energy = 10'd1023;
      2: r.region_energy = tie_energy;
      default: r.region_energy = ENERGY_W'($urandom_range(1023));
    endcase
    tie_energy = r.region_energy;
    // Mostly valid phi slots, sometimes indices that wrap modulo NPHI.
    r.phi_index = PHI_W'(($urandom_range(7) == 0) ? $urandom_range(31)
                                                  : $urandom_range(N_PHI - 1));
    r.eta_index = ETA_W'($urandom_range(31));
    r.region_overflow = ($urandom_range(3) == 0);
    r.last_region = last;
    return r;
  endfunction

  task automatic offer_region(input region_t r);
    result_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      region_valid <= 1'b0;
    end
    @(negedge clk);
    region_valid <= 1'b1;
    region_in <= r;
    do @(posedge clk); while (!region_ready);
    if (fold_region(r, res)) pending_results.insert(pending_results.size(), res);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    region_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * RESULT_LATENCY) @(posedge clk);
  endtask

  task automatic test_corner_events();
    // Zero energy gives a zero vector; the phi index wraps.
    offer_region(make_region(0, 31, 31, 1'b1, 1'b1));
    // A region at phi 0 leaves a missing vector pointing at pi.
    offer_region(make_region(1023, 0, 0, 1'b0, 1'b1));
    offer_region(make_region(1023, 9, 21, 1'b1, 1'b1));
    // Equal energies: the first region stays the peak.
    offer_region(make_region(500, 3, 4, 1'b0, 1'b0));
    offer_region(make_region(500, 5, 6, 1'b1, 1'b0));
    offer_region(make_region(100, 7, 8, 1'b1, 1'b1));
    // Opposite slots cancel.
    offer_region(make_region(700, 2, 1, 1'b0, 1'b0));
    offer_region(make_region(700, 11, 2, 1'b0, 1'b1));
    offer_region(make_region(1, 17, 30, 1'b0, 1'b0));
    offer_region(make_region(800, 22, 16, 1'b1, 1'b1));
    wait_for_results();
  endtask

  // An event longer than the region limit with every overflow flag set.
  task automatic test_region_limit();
    for (int i = 0; i < REGION_LIMIT + 2; i++)
      offer_region(make_region(1023, 0, i % 22, 1'b1, i == REGION_LIMIT + 1));
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int n_items, input int tx_pct, input int rx_pct);
    int sent;
    int len;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40);
      for (int i = 0; i < len; i++) begin
        offer_region(random_region(i == len - 1));
        sent++;
      end
    end
    wait_for_results();
  endtask

  // The receiver holds off while short events keep coming, so the record
  // queue fills and the input stalls.
  task automatic test_output_stall();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    @(posedge clk);
    stall_left = STALL_CYCLES;
    for (int ev = 0; ev < 12; ev++)
      for (int i = 0; i < 3; i++) offer_region(random_region(i == 2));
    wait_for_results();
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      result_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      result_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no expected result");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (result_out.missing_magnitude !== want.missing_magnitude) begin
          $error("missing_magnitude expected %0d actual %0d",
                 want.missing_magnitude, result_out.missing_magnitude);
          error_count++;
        end
        if (result_out.missing_angle !== want.missing_angle) begin
          $error("missing_angle expected %0d actual %0d",
                 $signed(want.missing_angle), $signed(result_out.missing_angle));
          error_count++;
        end
        if (result_out.overflow_count !== want.overflow_count) begin
          $error("overflow_count expected %0d actual %0d",
                 want.overflow_count, result_out.overflow_count);
          error_count++;
        end
        if (result_out.peak_energy !== want.peak_energy) begin
          $error("peak_energy expected %0d actual %0d",
                 want.peak_energy, result_out.peak_energy);
          error_count++;
        end
        if (result_out.peak_phi !== want.peak_phi) begin
          $error("peak_phi expected %0d actual %0d", want.peak_phi, result_out.peak_phi);
          error_count++;
        end
        if (result_out.peak_eta !== want.peak_eta) begin
          $error("peak_eta expected %0d actual %0d", want.peak_eta, result_out.peak_eta);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((region_valid && region_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    build_trig_tables();
    clear_event_state();
    // The corner events and the long event run with the sender idle 25 percent
    // of the time and the receiver 61 percent.
    tx_idle_pct = 25;
    rx_idle_pct = 61;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    test_corner_events();
    test_region_limit();
    test_random_traffic(20, 61, 25);
    test_output_stall();
    test_random_traffic(20, 0, 0);
    if (error_count == 0 && pending_results.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
